/* src/cfp_pkg.sv */
// Package for the camera frame parser: types, constants and codes.
// Shared by cfp_decode and camera_frame_parser_with_timeout.
`timescale 1ns / 1ps

package cfp_pkg;

	// Frame sizing
	localparam int MAX_LEN    = 20;
	localparam int STORE_SIZE = MAX_LEN + 5;
	localparam int POS_W      = $clog2(STORE_SIZE);
	localparam int LEN_W      = $clog2(MAX_LEN);

	// Header and kind bytes on the link
	localparam logic [7:0] SYNC_BYTE  = 8'hAA;
	localparam logic [7:0] LINK_BYTE  = 8'h05;
	localparam logic [7:0] KIND_BLOB  = 8'h41;
	localparam logic [7:0] KIND_LINE  = 8'h42;
	localparam logic [7:0] KIND_PAIR  = 8'h43;
	localparam logic [7:0] KIND_BYTES = 8'h44;

	// Timer
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	// Byte positions within a frame
	localparam logic [POS_W-1:0] POS_SYNC    = POS_W'(0);
	localparam logic [POS_W-1:0] POS_ID      = POS_W'(1);
	localparam logic [POS_W-1:0] POS_LINK    = POS_W'(2);
	localparam logic [POS_W-1:0] POS_KIND    = POS_W'(3);
	localparam logic [POS_W-1:0] POS_LEN     = POS_W'(4);
	localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(5);

	// Reported frame kinds
	localparam logic [2:0] FK_NONE  = 3'd0;
	localparam logic [2:0] FK_BLOB  = 3'd1;
	localparam logic [2:0] FK_LINE  = 3'd2;
	localparam logic [2:0] FK_PAIR  = 3'd3;
	localparam logic [2:0] FK_BYTES = 3'd4;

	// Operating modes
	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_BLOB = 2'd1;
	localparam logic [1:0] MODE_LINE = 2'd2;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef struct packed {
		op_t        opcode;
		logic [7:0] data_byte;
		logic [7:0] tick_ms;
	} item_t;

	typedef struct packed {
		logic               frame_valid;
		logic [2:0]         frame_kind;
		logic [1:0]         mode_now;
		logic               offline_now;
		logic signed [15:0] value_a;
		logic signed [15:0] value_b;
		logic signed [15:0] value_c;
		logic signed [15:0] value_d;
		logic signed [15:0] value_e;
		logic signed [15:0] value_f;
		logic signed [15:0] value_g;
	} result_t;

	// Decoded frame contents
	typedef struct packed {
		logic [2:0]         kind;
		logic signed [15:0] value_a;
		logic signed [15:0] value_b;
		logic signed [15:0] value_c;
		logic signed [15:0] value_d;
		logic signed [15:0] value_e;
		logic signed [15:0] value_f;
		logic signed [15:0] value_g;
	} dec_t;

endpackage

/* src/cfp_decode.sv */
// Frame decoder: maps the stored frame bytes to a kind and seven values.
// Depends on cfp_pkg.
`timescale 1ns / 1ps

module cfp_decode (
	input  logic [7:0]    frame_bytes [cfp_pkg::STORE_SIZE],
	output cfp_pkg::dec_t dec
);
	import cfp_pkg::*;

	// Big-endian signed word from two bytes.
	function automatic logic signed [15:0] word16(input logic [7:0] hi, input logic [7:0] lo);
		return $signed({hi, lo});
	endfunction

	// Byte zero-extended to a value.
	function automatic logic signed [15:0] byte16(input logic [7:0] b);
		return $signed({8'h00, b});
	endfunction

	// Select field layout by the kind byte; unknown kinds fall to user bytes.
	always_comb begin
		dec = '0;
		case (frame_bytes[3])
			KIND_BLOB: begin
				dec.kind    = FK_BLOB;
				dec.value_a = byte16(frame_bytes[5]);
				dec.value_b = byte16(frame_bytes[6]);
				dec.value_c = word16(frame_bytes[7], frame_bytes[8]);
				dec.value_d = word16(frame_bytes[9], frame_bytes[10]);
				dec.value_e = byte16(frame_bytes[11]);
			end
			KIND_LINE: begin
				dec.kind    = FK_LINE;
				dec.value_a = byte16(frame_bytes[5]);
				dec.value_b = word16(frame_bytes[6], frame_bytes[7]);
				dec.value_c = word16(frame_bytes[8], frame_bytes[9]);
				dec.value_d = byte16(frame_bytes[10]);
				dec.value_e = word16(frame_bytes[11], frame_bytes[12]);
				dec.value_f = word16(frame_bytes[13], frame_bytes[14]);
				dec.value_g = byte16(frame_bytes[15]);
			end
			KIND_PAIR: begin
				dec.kind    = FK_PAIR;
				dec.value_a = word16(frame_bytes[5], frame_bytes[6]);
				dec.value_b = word16(frame_bytes[7], frame_bytes[8]);
				dec.value_c = byte16(frame_bytes[9]);
			end
			default: begin
				dec.kind    = FK_BYTES;
				dec.value_a = byte16(frame_bytes[5]);
				dec.value_b = byte16(frame_bytes[6]);
				dec.value_c = byte16(frame_bytes[7]);
				dec.value_d = byte16(frame_bytes[8]);
				dec.value_e = byte16(frame_bytes[9]);
			end
		endcase
	end

endmodule

/* src/camera_frame_parser_with_timeout.sv */
// Camera link frame parser with offline timeout: top level.
// Each accepted transaction passes the input register, then the result register.
// Throughput: one transaction per cycle while result_ready does not stall the output.
// The frame store is a row of flip-flops read at fixed places by the decoder.
// Reset (arst_n low) clears parser, timer, frame store and flags at once and
// sets the timeout to 1000 ms; no clearing pass is needed.
`timescale 1ns / 1ps

module camera_frame_parser_with_timeout (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  cfp_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output cfp_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_wdata
);
	import cfp_pkg::*;

	logic             valid_s1;
	item_t            item_s1;
	logic             result_valid_q;
	result_t          result_q;
	logic             advance;

	logic [15:0]      timeout_q;
	logic [POS_W-1:0] pos_q;
	logic [LEN_W-1:0] len_q;
	logic [7:0]       sum_q;
	logic [7:0]       store_q [STORE_SIZE];
	logic [15:0]      silence_q;
	logic             offline_q;
	logic [1:0]       mode_q;

	logic [POS_W-1:0] pos_d;
	logic [LEN_W-1:0] len_d;
	logic [7:0]       sum_d;
	logic [15:0]      silence_d;
	logic             offline_d;
	logic [1:0]       mode_d;
	logic             good_frame;
	logic [7:0]       view [STORE_SIZE];
	logic [16:0]      silence_sum;
	logic [POS_W:0]   check_pos;
	dec_t             dec;
	result_t          result_d;

	// Handshake: the result register parts the two sides.
	assign advance      = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready   = !valid_s1 || advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Store contents as seen after the current byte is written.
	always_comb begin
		view = store_q;
		if (item_s1.opcode == OP_BYTE) begin
			view[pos_q] = item_s1.data_byte;
		end
	end

	cfp_decode u_decode (
		.frame_bytes (view),
		.dec         (dec)
	);

	assign silence_sum = {1'b0, silence_q} + {9'd0, item_s1.tick_ms};
	assign check_pos   = {{(POS_W + 1 - LEN_W){1'b0}}, len_q} + (POS_W + 1)'(5);

	// Parser and timer next state for the transaction in stage one.
	always_comb begin
		pos_d      = pos_q;
		len_d      = len_q;
		sum_d      = sum_q;
		silence_d  = silence_q;
		offline_d  = offline_q;
		mode_d     = mode_q;
		good_frame = 1'b0;
		if (item_s1.opcode == OP_BYTE) begin
			unique case (pos_q)
				POS_SYNC: begin
					sum_d = item_s1.data_byte;
					pos_d = (item_s1.data_byte == SYNC_BYTE) ? POS_ID : POS_SYNC;
				end
				POS_ID: begin
					sum_d = sum_q + item_s1.data_byte;
					pos_d = POS_LINK;
				end
				POS_LINK: begin
					sum_d = sum_q + item_s1.data_byte;
					pos_d = (item_s1.data_byte == LINK_BYTE) ? POS_KIND : POS_SYNC;
				end
				POS_KIND: begin
					sum_d = sum_q + item_s1.data_byte;
					pos_d = (item_s1.data_byte >= KIND_BLOB && item_s1.data_byte <= KIND_BYTES)
						? POS_LEN : POS_SYNC;
				end
				POS_LEN: begin
					sum_d = sum_q + item_s1.data_byte;
					if (item_s1.data_byte < 8'(MAX_LEN)) begin
						len_d = item_s1.data_byte[LEN_W-1:0];
						pos_d = POS_PAYLOAD;
					end else begin
						pos_d = POS_SYNC;
					end
				end
				default: begin
					if ({1'b0, pos_q} >= check_pos) begin
						// Checksum byte closes the frame.
						pos_d = POS_SYNC;
						if (sum_q == item_s1.data_byte) begin
							good_frame = 1'b1;
							silence_d  = '0;
							offline_d  = 1'b0;
							if (dec.kind == FK_BLOB) begin
								mode_d = MODE_BLOB;
							end else if (dec.kind == FK_LINE) begin
								mode_d = MODE_LINE;
							end
						end
					end else begin
						sum_d = sum_q + item_s1.data_byte;
						pos_d = pos_q + POS_W'(1);
					end
				end
			endcase
		end else begin
			// Tick: count silence, or go offline once the timeout is reached.
			if (silence_q < timeout_q) begin
				silence_d = silence_sum[16] ? 16'hFFFF : silence_sum[15:0];
			end else begin
				offline_d = 1'b1;
				mode_d    = MODE_NONE;
			end
		end
	end

	// Result assembly.
	always_comb begin
		result_d             = '0;
		result_d.frame_valid = good_frame;
		result_d.mode_now    = mode_d;
		result_d.offline_now = offline_d;
		if (good_frame) begin
			result_d.frame_kind = dec.kind;
			result_d.value_a    = dec.value_a;
			result_d.value_b    = dec.value_b;
			result_d.value_c    = dec.value_c;
			result_d.value_d    = dec.value_d;
			result_d.value_e    = dec.value_e;
			result_d.value_f    = dec.value_f;
			result_d.value_g    = dec.value_g;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	// Parser, timer and frame store state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_SYNC;
			len_q     <= '0;
			sum_q     <= '0;
			silence_q <= '0;
			offline_q <= 1'b0;
			mode_q    <= MODE_NONE;
			for (int i = 0; i < STORE_SIZE; i++) begin
				store_q[i] <= '0;
			end
		end else if (advance) begin
			pos_q     <= pos_d;
			len_q     <= len_d;
			sum_q     <= sum_d;
			silence_q <= silence_d;
			offline_q <= offline_d;
			mode_q    <= mode_d;
			if (item_s1.opcode == OP_BYTE) begin
				store_q[pos_q] <= item_s1.data_byte;
			end
		end
	end

`ifndef SYNTHESIS
	// A good frame always brings the link back online.
	a_frame_online: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.frame_valid |-> !result.offline_now)
		else $error("good frame reported while offline");

	// Without a frame, kind and values are zero.
	a_no_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.frame_valid |->
			result.frame_kind == FK_NONE && result.value_a == 16'sd0
			&& result.value_g == 16'sd0)
		else $error("frame fields set without a good frame");

	// A mode is only held while the link is online.
	a_mode_online: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != MODE_NONE |-> !offline_q)
		else $error("mode held while offline");

	// The parser position never passes the checksum place of the frame.
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q >= POS_PAYLOAD |-> {1'b0, pos_q} <= check_pos)
		else $error("parser position beyond checksum");
`endif

endmodule

/* dv/cfp_frame_checker.sv */
// Frame checker for the camera frame parser: watches both channels and the
// timeout register port, predicts every result and compares it field by field.
// Depends on cfp_pkg for the transaction types and the link constants.
`timescale 1ns / 1ps

module cfp_frame_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_ready,
	input  cfp_pkg::item_t   item,
	input  logic             result_valid,
	input  logic             result_ready,
	input  cfp_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_wdata,
	output int               fail_count,
	output int               reports_due,
	output int               good_frames,
	output int               offline_reports
);

	import cfp_pkg::*;

	// Shadow copy of the parser, timer and timeout register.
	logic [POS_W-1:0] pos_q;
	logic [LEN_W-1:0] len_q;
	logic [7:0]       sum_q;
	logic [7:0]       store_q [STORE_SIZE];
	logic [15:0]      silence_q;
	logic             offline_q;
	logic [1:0]       mode_q;
	logic [15:0]      timeout_q;

	// Results predicted for accepted transactions, oldest first.
	result_t parser_outputs_due [$];

	function automatic logic signed [15:0] store_word(input int at);
		return {store_q[at], store_q[at + 1]};
	endfunction

	function automatic logic signed [15:0] store_byte(input int at);
		return {8'h00, store_q[at]};
	endfunction

	function automatic string describe(input result_t x);
		return $sformatf({"valid=%0d kind=%0d mode=%0d offline=%0d ",
			"a=%0d b=%0d c=%0d d=%0d e=%0d f=%0d g=%0d"},
			x.frame_valid, x.frame_kind, x.mode_now, x.offline_now,
			x.value_a, x.value_b, x.value_c, x.value_d,
			x.value_e, x.value_f, x.value_g);
	endfunction

	// Decode the completed frame held in the store by its kind byte.
	task automatic decode_frame(inout result_t r);
		if (store_q[3] == KIND_BLOB) begin
			r.frame_kind = FK_BLOB;
			r.value_a = store_byte(5);
			r.value_b = store_byte(6);
			r.value_c = store_word(7);
			r.value_d = store_word(9);
			r.value_e = store_byte(11);
			mode_q = MODE_BLOB;
		end else if (store_q[3] == KIND_LINE) begin
			r.frame_kind = FK_LINE;
			r.value_a = store_byte(5);
			r.value_b = store_word(6);
			r.value_c = store_word(8);
			r.value_d = store_byte(10);
			r.value_e = store_word(11);
			r.value_f = store_word(13);
			r.value_g = store_byte(15);
			mode_q = MODE_LINE;
		end else if (store_q[3] == KIND_PAIR) begin
			r.frame_kind = FK_PAIR;
			r.value_a = store_word(5);
			r.value_b = store_word(7);
			r.value_c = store_byte(9);
		end else begin
			r.frame_kind = FK_BYTES;
			r.value_a = store_byte(5);
			r.value_b = store_byte(6);
			r.value_c = store_byte(7);
			r.value_d = store_byte(8);
			r.value_e = store_byte(9);
		end
	endtask

	// Advance the shadow parser or timer by one transaction.
	task automatic advance_parser(input item_t it, output result_t r);
		logic [POS_W-1:0] at;
		logic [7:0]       b;
		logic [16:0]      grown;
		r = '0;
		b = it.data_byte;
		if (it.opcode == OP_BYTE) begin
			at = pos_q;
			if (int'(at) < STORE_SIZE)
				store_q[at] = b;
			if (at == POS_SYNC) begin
				sum_q = b;
				pos_q = (b == SYNC_BYTE) ? POS_ID : POS_SYNC;
			end else if (at == POS_ID) begin
				sum_q = sum_q + b;
				pos_q = POS_LINK;
			end else if (at == POS_LINK) begin
				sum_q = sum_q + b;
				pos_q = (b == LINK_BYTE) ? POS_KIND : POS_SYNC;
			end else if (at == POS_KIND) begin
				sum_q = sum_q + b;
				pos_q = (b >= KIND_BLOB && b <= KIND_BYTES) ? POS_LEN : POS_SYNC;
			end else if (at == POS_LEN) begin
				sum_q = sum_q + b;
				if (int'(b) < MAX_LEN) begin
					len_q = b[LEN_W-1:0];
					pos_q = POS_PAYLOAD;
				end else begin
					pos_q = POS_SYNC;
				end
			end else if (int'(at) >= int'(len_q) + int'(POS_PAYLOAD)) begin
				// Checksum position: a match reports the frame and revives the link.
				if (sum_q == b) begin
					decode_frame(r);
					r.frame_valid = 1'b1;
					silence_q = '0;
					offline_q = 1'b0;
				end
				pos_q = POS_SYNC;
			end else begin
				sum_q = sum_q + b;
				pos_q = at + 1'b1;
			end
		end else begin
			// Tick: count silence, saturating, or flag the link offline.
			if (silence_q < timeout_q) begin
				grown = {1'b0, silence_q} + it.tick_ms;
				silence_q = grown[16] ? 16'hFFFF : grown[15:0];
			end else begin
				offline_q = 1'b1;
				mode_q = MODE_NONE;
			end
		end
		r.mode_now = mode_q;
		r.offline_now = offline_q;
	endtask

	// Compare accepted results, follow register writes, predict new transactions.
	always @(posedge clk or negedge arst_n) begin
		result_t due;
		result_t got;
		string   bad;
		if (!arst_n) begin
			pos_q = POS_SYNC;
			len_q = '0;
			sum_q = '0;
			foreach (store_q[i])
				store_q[i] = '0;
			silence_q = '0;
			offline_q = 1'b0;
			mode_q = MODE_NONE;
			timeout_q = TIMEOUT_RESET;
			parser_outputs_due.delete();
			fail_count = 0;
			reports_due = 0;
			good_frames = 0;
			offline_reports = 0;
		end else begin
			if (result_valid && result_ready) begin
				got = result;
				if (parser_outputs_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: %s", describe(got));
				end else begin
					due = parser_outputs_due.pop_front();
					bad = "";
					if (got.frame_valid !== due.frame_valid) bad = {bad, " frame_valid"};
					if (got.frame_kind !== due.frame_kind) bad = {bad, " frame_kind"};
					if (got.mode_now !== due.mode_now) bad = {bad, " mode_now"};
					if (got.offline_now !== due.offline_now) bad = {bad, " offline_now"};
					if (got.value_a !== due.value_a) bad = {bad, " value_a"};
					if (got.value_b !== due.value_b) bad = {bad, " value_b"};
					if (got.value_c !== due.value_c) bad = {bad, " value_c"};
					if (got.value_d !== due.value_d) bad = {bad, " value_d"};
					if (got.value_e !== due.value_e) bad = {bad, " value_e"};
					if (got.value_f !== due.value_f) bad = {bad, " value_f"};
					if (got.value_g !== due.value_g) bad = {bad, " value_g"};
					if (bad != "") begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch in%s at %0t", bad, $realtime);
							$display("  expected %s", describe(due));
							$display("  actual   %s", describe(got));
						end
					end
				end
			end
			if (cfg_we)
				timeout_q = cfg_wdata;
			if (item_valid && item_ready) begin
				advance_parser(item, due);
				parser_outputs_due.push_back(due);
				if (due.frame_valid)
					good_frames++;
				if (due.offline_now)
					offline_reports++;
			end
			reports_due = parser_outputs_due.size();
		end
	end

endmodule

/* dv/camera_frame_parser_with_timeout_test.sv */
// Testbench top for the camera frame parser: drives link bytes, ticks and
// timeout writes, and gives the verdict from the frame checker's count.
// Depends on cfp_pkg, camera_frame_parser_with_timeout and cfp_frame_checker.
`timescale 1ns / 1ps

module camera_frame_parser_with_timeout_test;

	import cfp_pkg::*;

	localparam int IDLE_LIMIT   = 4000;
	localparam int HOLD_CYCLES  = 80;
	localparam int PHASE_ITEMS  = 70;
	localparam int SETTLE_TICKS = 10;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	item_t       item;
	logic        result_valid;
	logic        result_ready;
	result_t     result;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	int fail_count;
	int reports_due;
	int good_frames;
	int offline_reports;
	int sent_items;
	int phase_items;
	int settings_run;
	int idle_cycles;

	// Traffic shaping: steady for sender and receiver, eager for the sender, hold_req for the receiver.
	bit steady;
	bit eager;
	bit hold_req;

	always #5 clk = ~clk;

	camera_frame_parser_with_timeout DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	cfp_frame_checker frame_watch (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_ready      (item_ready),
		.item            (item),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.result          (result),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.fail_count      (fail_count),
		.reports_due     (reports_due),
		.good_frames     (good_frames),
		.offline_reports (offline_reports)
	);

	// Watchdog: ends the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver: random back-pressure, with one long hold on request.
	initial begin : receiver
		int stall;
		int r;
		bit hold_done;
		stall = 0;
		hold_done = 1'b0;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
				result_ready <= 1'b1;
			end else if (steady) begin
				result_ready <= 1'b1;
			end else if (stall > 0) begin
				result_ready <= 1'b0;
				stall--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					result_ready <= 1'b1;
				end else begin
					result_ready <= 1'b0;
					stall = (r < 96) ? $urandom_range(0, 3) : $urandom_range(10, 40);
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (eager || steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] payload_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] tick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 8'($urandom_range(0, 3));
		if (r < 50)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	// Offer one transaction from a falling edge and return at the falling edge
	// after it is taken; valid is left high for a follow-on transaction.
	task automatic send_item(input item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		sent_items++;
		phase_items++;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		item_t it;
		it.opcode = OP_BYTE;
		it.data_byte = b;
		it.tick_ms = 8'($urandom);
		send_item(it);
	endtask

	task automatic send_tick(input logic [7:0] t);
		item_t it;
		it.opcode = OP_TICK;
		it.data_byte = 8'($urandom);
		it.tick_ms = t;
		send_item(it);
	endtask

	// A complete frame, optionally with a spoilt checksum and ticks woven in.
	task automatic send_frame(input logic [7:0] kind, input logic [7:0] id, input int len,
			input bit spoil, input bit with_ticks);
		logic [7:0] frame_bytes [$];
		logic [7:0] sum;
		frame_bytes.push_back(SYNC_BYTE);
		frame_bytes.push_back(id);
		frame_bytes.push_back(LINK_BYTE);
		frame_bytes.push_back(kind);
		frame_bytes.push_back(8'(len));
		for (int i = 0; i < len; i++)
			frame_bytes.push_back(payload_byte());
		sum = '0;
		foreach (frame_bytes[i])
			sum = sum + frame_bytes[i];
		if (spoil)
			sum = sum + 8'($urandom_range(1, 255));
		frame_bytes.push_back(sum);
		foreach (frame_bytes[i]) begin
			if (with_ticks && $urandom_range(0, 9) == 0)
				send_tick(tick_value());
			send_byte(frame_bytes[i]);
		end
	endtask

	// Headers that break off early, and plain line noise.
	task automatic send_broken_header();
		logic [7:0] b;
		int         variant;
		variant = $urandom_range(0, 3);
		if (variant == 3) begin
			repeat ($urandom_range(1, 4))
				send_byte(($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom));
		end else begin
			send_byte(SYNC_BYTE);
			send_byte(8'($urandom));
			if (variant == 0) begin
				b = 8'($urandom);
				send_byte((b == LINK_BYTE) ? 8'h06 : b);
			end else begin
				send_byte(LINK_BYTE);
				if (variant == 1) begin
					b = 8'($urandom);
					send_byte((b >= KIND_BLOB && b <= KIND_BYTES) ? 8'h45 : b);
				end else begin
					send_byte(KIND_BLOB + 8'($urandom_range(0, 3)));
					send_byte(($urandom_range(0, 1) == 0) ? 8'(MAX_LEN)
						: 8'($urandom_range(MAX_LEN, 255)));
				end
			end
		end
	endtask

	// Mostly well-formed frames with random content, mixed with ticks and noise.
	task automatic random_traffic(input int quota);
		logic [7:0] kind;
		int         len;
		int         r;
		phase_items = 0;
		while (phase_items < quota) begin
			if ($urandom_range(0, 19) == 0)
				steady = !steady;
			r = $urandom_range(0, 99);
			if (r < 55) begin
				kind = KIND_BLOB + 8'($urandom_range(0, 3));
				len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 11)
					: $urandom_range(12, MAX_LEN - 1);
				send_frame(kind, 8'($urandom), len, $urandom_range(0, 7) == 0, 1'b1);
			end else if (r < 80) begin
				repeat ($urandom_range(1, 3))
					send_tick(tick_value());
			end else begin
				send_broken_header();
			end
		end
	endtask

	// Hold the sender until every predicted result has come back.
	task automatic drain();
		item_valid <= 1'b0;
		while (reports_due != 0)
			@(negedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	// Stimulus and verdict.
	initial begin
		logic [15:0] timeouts [7];
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		sent_items = 0;
		phase_items = 0;
		settings_run = 1;
		steady = 1'b0;
		eager = 1'b0;
		hold_req = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: tick extremes, a short frame reading the checksum and
		// cleared store, a bad link byte, an oversize length, a bad checksum.
		send_tick(8'hFF);
		send_frame(KIND_BYTES, 8'h00, 0, 1'b0, 1'b0);
		send_byte(SYNC_BYTE);
		send_byte(8'hFF);
		send_byte(8'h06);
		send_byte(SYNC_BYTE);
		send_byte(8'h01);
		send_byte(LINK_BYTE);
		send_byte(KIND_BLOB);
		send_byte(8'(MAX_LEN));
		send_frame(KIND_PAIR, 8'h7F, 1, 1'b1, 1'b0);
		send_tick(8'h00);

		// Random traffic at the reset timeout.
		random_traffic(PHASE_ITEMS);

		// Long receiver hold while the sender keeps offering, so the block fills.
		hold_req = 1'b1;
		eager = 1'b1;
		random_traffic(40);
		eager = 1'b0;

		// Sender pauses until the block has emptied.
		drain();

		timeouts[0] = 16'd1;
		timeouts[1] = 16'd60000;
		timeouts[2] = 16'd0;
		timeouts[3] = 16'hFFFF;
		timeouts[4] = 16'($urandom_range(1, 60000));
		timeouts[5] = 16'($urandom_range(1, 800));
		timeouts[6] = TIMEOUT_RESET;
		foreach (timeouts[i]) begin
			write_timeout(timeouts[i]);
			if (timeouts[i] == 16'hFFFF) begin
				// Counter saturation: clear it with a good frame, then run it past the top.
				send_frame(KIND_BLOB, 8'h10, 7, 1'b0, 1'b0);
				send_tick(8'd200);
				repeat (260) send_tick(8'hFF);
			end
			random_traffic(PHASE_ITEMS);
		end

		drain();
		repeat (SETTLE_TICKS) @(negedge clk);
		$display("Ran %0d transactions under %0d timeout settings with back-pressure on both sides.",
			sent_items, settings_run);
		$display("Saw %0d good frames decoded and %0d results with the link offline.",
			good_frames, offline_reports);
		if (fail_count == 0 && reports_due == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
